[rtl/core/fme_pkg.sv]
// Package for the fuzzy membership evaluator.
// Holds the shared types, register indexes and default widths.
// Has no dependencies of its own.
package fme_pkg;

    localparam int VALUE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 15;
    localparam int CFG_INDEX_BITS    = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE_MODE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_A    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_B    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_C    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POINT_D    = 3'd4;

    typedef enum logic [1:0] {
        SHAPE_TRIANGLE  = 2'd0,
        SHAPE_TRAPEZOID = 2'd1,
        SHAPE_L         = 2'd2,
        SHAPE_GAMMA     = 2'd3
    } fme_shape_t;

    // What the final stage shows: zero, full membership, or the quotient
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_RAMP = 2'd2
    } fme_kind_t;

    typedef struct packed {
        logic      valid;
        fme_kind_t kind;
    } fme_ctl_t;

endpackage

[rtl/core/fme_front.sv]
// Front stage of the fuzzy membership evaluator: range tests and ramp operands.
// Registers numerator, denominator and result kind for the divider chain.
// Depends on fme_pkg.
module fme_front #(
    parameter int VALUE_BITS = fme_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic signed [VALUE_BITS-1:0] crisp_value,
    input  fme_pkg::fme_shape_t          shape_mode,
    input  logic signed [VALUE_BITS-1:0] point_a,
    input  logic signed [VALUE_BITS-1:0] point_b,
    input  logic signed [VALUE_BITS-1:0] point_c,
    input  logic signed [VALUE_BITS-1:0] point_d,
    output fme_pkg::fme_ctl_t            ctl_out,
    output logic [VALUE_BITS-1:0]        num_out,
    output logic [VALUE_BITS-1:0]        den_out
);
    import fme_pkg::*;

    logic signed [VALUE_BITS-1:0] num_hi, num_lo, den_hi, den_lo;
    logic signed [VALUE_BITS:0]   num_wide, den_wide;
    fme_kind_t                    kind_sel;
    fme_kind_t                    kind_fix;
    fme_ctl_t                     ctl_reg, ctl_next;
    logic [VALUE_BITS-1:0]        num_reg, den_reg;

    // Pick the first matching branch and its ramp operands
    always_comb
    begin
        num_hi   = crisp_value;
        num_lo   = point_a;
        den_hi   = point_b;
        den_lo   = point_a;
        kind_sel = KIND_ZERO;
        case (shape_mode)
            SHAPE_TRIANGLE:
            begin
                if (crisp_value >= point_a && crisp_value <= point_b)
                begin
                    kind_sel = KIND_RAMP;
                end
                else if (crisp_value >= point_b && crisp_value <= point_c)
                begin
                    kind_sel = KIND_RAMP;
                    num_hi   = point_c;
                    num_lo   = crisp_value;
                    den_hi   = point_c;
                    den_lo   = point_b;
                end
            end
            SHAPE_TRAPEZOID:
            begin
                if (crisp_value >= point_a && crisp_value <= point_b)
                begin
                    kind_sel = KIND_RAMP;
                end
                else if (crisp_value >= point_b && crisp_value <= point_c)
                begin
                    kind_sel = KIND_ONE;
                end
                else if (crisp_value >= point_c && crisp_value <= point_d)
                begin
                    kind_sel = KIND_RAMP;
                    num_hi   = point_d;
                    num_lo   = crisp_value;
                    den_hi   = point_d;
                    den_lo   = point_c;
                end
            end
            SHAPE_L:
            begin
                if (crisp_value <= point_a)
                begin
                    kind_sel = KIND_ONE;
                end
                else if (crisp_value < point_b)
                begin
                    kind_sel = KIND_RAMP;
                    num_hi   = point_b;
                    num_lo   = crisp_value;
                end
            end
            SHAPE_GAMMA:
            begin
                if (crisp_value > point_a && crisp_value < point_b)
                begin
                    kind_sel = KIND_RAMP;
                end
                else if (crisp_value >= point_b)
                begin
                    kind_sel = KIND_ONE;
                end
            end
            default:
            begin
                kind_sel = KIND_ZERO;
            end
        endcase
    end

    // Both differences are non-negative whenever a ramp is selected
    assign num_wide = {num_hi[VALUE_BITS-1], num_hi} - {num_lo[VALUE_BITS-1], num_lo};
    assign den_wide = {den_hi[VALUE_BITS-1], den_hi} - {den_lo[VALUE_BITS-1], den_lo};

    // A ramp with coinciding breakpoints counts as full membership
    always_comb
    begin
        kind_fix = kind_sel;
        if (kind_sel == KIND_RAMP && den_wide == '0)
        begin
            kind_fix = KIND_ONE;
        end
    end

    always_comb
    begin
        ctl_next.valid = accept;
        ctl_next.kind  = kind_fix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, kind: KIND_ZERO};
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_wide[VALUE_BITS-1:0];
        den_reg <= den_wide[VALUE_BITS-1:0];
    end

    assign ctl_out = ctl_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;

endmodule

[rtl/core/fme_cell.sv]
// One restoring-division cell of the fuzzy membership evaluator.
// Produces one quotient bit per item and hands the remainder to its neighbor.
// Depends on fme_pkg.
module fme_cell #(
    parameter int VALUE_BITS    = fme_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = fme_pkg::FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fme_pkg::fme_ctl_t          ctl_in,
    input  logic [VALUE_BITS:0]        rem_in,
    input  logic [VALUE_BITS-1:0]      den_in,
    input  logic [FRACTION_BITS:0]     quo_in,
    output fme_pkg::fme_ctl_t          ctl_out,
    output logic [VALUE_BITS:0]        rem_out,
    output logic [VALUE_BITS-1:0]      den_out,
    output logic [FRACTION_BITS:0]     quo_out
);
    import fme_pkg::*;

    logic                     take;
    logic [VALUE_BITS:0]      diff;
    logic [VALUE_BITS:0]      kept;
    fme_ctl_t                 ctl_reg;
    logic [VALUE_BITS:0]      rem_reg, rem_next;
    logic [VALUE_BITS-1:0]    den_reg;
    logic [FRACTION_BITS:0]   quo_reg, quo_next;

    // Remainder stays below the divisor, so the doubled value fits
    assign take     = rem_in >= {1'b0, den_in};
    assign diff     = rem_in - {1'b0, den_in};
    assign kept     = take ? diff : rem_in;
    assign rem_next = {kept[VALUE_BITS-1:0], 1'b0};
    assign quo_next = {quo_in[FRACTION_BITS-1:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, kind: KIND_ZERO};
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        quo_reg <= quo_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

[rtl/core/fuzzy_membership_evaluator.sv]
// Top level of the fuzzy membership evaluator (fuzzifier).
// Instantiates fme_front and a chain of fme_cell stages; depends on fme_pkg.
//
// Usage:
//   Input: raise start with crisp_value; the transfer happens at a rising
//   edge where start is high and busy is low. busy is high only in the first
//   cycle after reset, so an item can be accepted every cycle after that.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
//   shape_mode (0), point_a..point_d (1..4); other indexes are dropped.
//   cfg_ready is always high. Write only while no item is in flight.
//   Result: degree is shown with done for exactly one cycle; the receiver
//   cannot stall, so every result is a transfer on its single cycle.
// Pipeline: one range-test stage, one cell per quotient bit (FRACTION_BITS + 1
//   cells), one output register.
// Throughput: one item per cycle; each cell of the division chain works on
//   a different item and hands its remainder to the next cell every cycle.
// Reset: asynchronous, active low; clears the configuration (triangle with all
//   breakpoints at zero) and the valid and done flags, sets busy, drops any item in flight.
module fuzzy_membership_evaluator #(
    parameter int VALUE_BITS    = fme_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = fme_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [VALUE_BITS-1:0]        crisp_value,
    output logic                                done,
    output logic [FRACTION_BITS:0]              degree,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fme_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [VALUE_BITS-1:0]               cfg_data
);
    import fme_pkg::*;

    localparam int NUM_CELLS = FRACTION_BITS + 1;
    localparam int LATENCY   = FRACTION_BITS + 3;
    localparam logic [FRACTION_BITS:0] ONE_FIXED = {1'b1, {FRACTION_BITS{1'b0}}};

    // Configuration registers
    fme_shape_t                   shape_mode_reg;
    logic signed [VALUE_BITS-1:0] point_a_reg, point_b_reg, point_c_reg, point_d_reg;
    logic                         cfg_write;

    // Handshake and output registers
    logic                         busy_reg;
    logic                         done_reg, done_next;
    logic [FRACTION_BITS:0]       degree_reg, degree_next;
    logic                         accept;

    // Chain links; link 0 is the front stage output
    fme_ctl_t                     ctl_link [NUM_CELLS+1];
    logic [VALUE_BITS:0]          rem_link [NUM_CELLS+1];
    logic [VALUE_BITS-1:0]        den_link [NUM_CELLS+1];
    logic [FRACTION_BITS:0]       quo_link [NUM_CELLS+1];
    logic [VALUE_BITS-1:0]        front_num;

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Hold busy for one cycle out of reset, then take items every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Register writes; indexes past point_d are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg <= SHAPE_TRIANGLE;
            point_a_reg    <= '0;
            point_b_reg    <= '0;
            point_c_reg    <= '0;
            point_d_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SHAPE_MODE: shape_mode_reg <= fme_shape_t'(cfg_data[1:0]);
                REG_POINT_A:    point_a_reg    <= cfg_data;
                REG_POINT_B:    point_b_reg    <= cfg_data;
                REG_POINT_C:    point_c_reg    <= cfg_data;
                REG_POINT_D:    point_d_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    fme_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .crisp_value (crisp_value),
        .shape_mode  (shape_mode_reg),
        .point_a     (point_a_reg),
        .point_b     (point_b_reg),
        .point_c     (point_c_reg),
        .point_d     (point_d_reg),
        .ctl_out     (ctl_link[0]),
        .num_out     (front_num),
        .den_out     (den_link[0])
    );

    // Numerator never exceeds the denominator on a ramp, so the dividend
    // enters the chain unshifted and the quotient needs FRACTION_BITS+1 bits
    assign rem_link[0] = {1'b0, front_num};
    assign quo_link[0] = '0;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        fme_cell #(
            .VALUE_BITS    (VALUE_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_link[i]),
            .rem_in  (rem_link[i]),
            .den_in  (den_link[i]),
            .quo_in  (quo_link[i]),
            .ctl_out (ctl_link[i+1]),
            .rem_out (rem_link[i+1]),
            .den_out (den_link[i+1]),
            .quo_out (quo_link[i+1])
        );
    end

    // Select the final degree from the kind carried down the chain
    always_comb
    begin
        done_next = ctl_link[NUM_CELLS].valid;
        case (ctl_link[NUM_CELLS].kind)
            KIND_ZERO: degree_next = '0;
            KIND_ONE:  degree_next = ONE_FIXED;
            KIND_RAMP: degree_next = quo_link[NUM_CELLS];
            default:   degree_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        degree_reg <= degree_next;
    end

    assign done   = done_reg;
    assign degree = degree_reg;

`ifndef SYNTH
    // Every accepted item leaves after exactly the pipeline latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not complete on time");

    // No result without a matching earlier accepted item
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without matching transfer");

    // Degree never exceeds full membership
    a_degree_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (degree <= ONE_FIXED))
        else $error("degree above one");

    // A full-membership kind at the chain output is shown as a degree of one
    a_kind_one: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_link[NUM_CELLS].valid && ctl_link[NUM_CELLS].kind == KIND_ONE)
        |=> (done && degree == ONE_FIXED))
        else $error("full membership not shown as one");
`endif

endmodule

[tb/tb_fuzzy_membership_evaluator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for fuzzy_membership_evaluator: a queue-fed driver, a result
// monitor and a built-in membership predictor checking each degree in order.
// Depends on fme_pkg and the fuzzy_membership_evaluator RTL.
module tb_fuzzy_membership_evaluator;

    import fme_pkg::*;

    localparam int VALUE_BITS    = VALUE_BITS_DEF;
    localparam int FRACTION_BITS = FRACTION_BITS_DEF;
    // Accepting edge to result edge
    localparam int LATENCY       = FRACTION_BITS + 3;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int NO_IDLE_PHASE = 5;
    localparam int MAX_REPORTS   = 100;
    localparam longint FULL_DEGREE = longint'(1) << FRACTION_BITS;
    localparam time TIMEOUT_NS   = 1_000_000;

    typedef logic signed [VALUE_BITS-1:0] crisp_t;
    typedef logic [VALUE_BITS-1:0]        cfg_word_t;
    typedef logic [FRACTION_BITS:0]       degree_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    crisp_t                    crisp_value = '0;
    logic                      done;
    degree_t                   degree;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    cfg_word_t                 cfg_data    = '0;

    // Shadow copy of the block's registers, updated on each config transfer
    fme_shape_t set_shape = SHAPE_TRIANGLE;
    crisp_t     set_a     = '0;
    crisp_t     set_b     = '0;
    crisp_t     set_c     = '0;
    crisp_t     set_d     = '0;

    crisp_t  crisp_queue[$];       // samples waiting to be driven
    degree_t expected_degrees[$];  // predicted degrees, oldest first
    int      issued_count    = 0;
    int      accepted_count  = 0;
    int      result_count    = 0;
    int      mismatch_count  = 0;
    int      idle_pct        = 37;
    int      pts[4];               // breakpoints a..d of the shape being built

    fuzzy_membership_evaluator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .crisp_value (crisp_value),
        .done        (done),
        .degree      (degree),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scaled ramp num/den in Q1.15; coincident breakpoints count as full membership
    function automatic longint ramp_fraction(input longint num, input longint den);
        longint q;
        if (den == 0)
            return FULL_DEGREE;
        q = (num << FRACTION_BITS) / den;
        return (q > FULL_DEGREE) ? FULL_DEGREE : q;
    endfunction

    // Degree of membership of one sample under the shadow registers.
    // Range tests run in a fixed order; the first one that holds decides.
    function automatic degree_t membership_degree(input crisp_t crisp);
        longint x;
        longint a;
        longint b;
        longint c;
        longint d;
        longint deg;
        x   = crisp;
        a   = set_a;
        b   = set_b;
        c   = set_c;
        d   = set_d;
        deg = 0;
        case (set_shape)
            SHAPE_TRIANGLE:
            begin
                if (x >= a && x <= b)
                    deg = ramp_fraction(x - a, b - a);
                else if (x >= b && x <= c)
                    deg = ramp_fraction(c - x, c - b);
            end
            SHAPE_TRAPEZOID:
            begin
                if (x >= a && x <= b)
                    deg = ramp_fraction(x - a, b - a);
                else if (x >= b && x <= c)
                    deg = FULL_DEGREE;
                else if (x >= c && x <= d)
                    deg = ramp_fraction(d - x, d - c);
            end
            SHAPE_L:
            begin
                if (x <= a)
                    deg = FULL_DEGREE;
                else if (x < b)
                    deg = ramp_fraction(b - x, b - a);
            end
            default:
            begin
                if (x > a && x < b)
                    deg = ramp_fraction(x - a, b - a);
                else if (x >= b)
                    deg = FULL_DEGREE;
            end
        endcase
        return degree_t'(deg);
    endfunction

    function automatic int clamp_value(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Pick breakpoints: mostly ordered with tight, medium or wide spacing,
    // some coincident, some pinned to the range ends, some in no order at all.
    function automatic void make_points();
        int kind;
        int span;
        int k;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            case ($urandom_range(0, 2))
                0:       span = 3;
                1:       span = 200;
                default: span = 20000;
            endcase
            pts[0] = int'($urandom_range(0, 65535)) - 32768;
            for (k = 1; k < 4; k++)
                pts[k] = clamp_value(pts[k-1] + int'($urandom_range(0, span)));
        end
        else if (kind == 6)
        begin
            pts[0] = int'($urandom_range(0, 65535)) - 32768;
            for (k = 1; k < 4; k++)
                pts[k] = pts[0];
        end
        else if (kind == 7)
        begin
            pts[0] = -32768;
            pts[1] = -int'($urandom_range(0, 32768));
            pts[2] = int'($urandom_range(0, 32767));
            pts[3] = 32767;
        end
        else
        begin
            for (k = 0; k < 4; k++)
                pts[k] = int'($urandom_range(0, 65535)) - 32768;
        end
    endfunction

    // Samples cluster around breakpoints and inside the ramps, with some
    // range extremes and plain uniform noise mixed in.
    function automatic int pick_crisp();
        int i;
        int j;
        int lo;
        int hi;
        i  = $urandom_range(0, 3);
        j  = $urandom_range(0, 3);
        lo = (pts[i] < pts[j]) ? pts[i] : pts[j];
        hi = (pts[i] < pts[j]) ? pts[j] : pts[i];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return clamp_value(pts[i] + int'($urandom_range(0, 6)) - 3);
            5, 6:          return lo + int'($urandom_range(0, hi - lo));
            7:             return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default:       return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t ns  MISMATCH  %s", $time, what);
        mismatch_count++;
    endtask

    // Call at a rising edge; return at the edge of the transfer with valid still high
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input cfg_word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Load shape and pts[] into the block; random upper bits on the shape word
    // must be ignored, and a stray index past point_d must change nothing.
    task automatic load_shape(input fme_shape_t shape, input bit stray);
        write_register(REG_SHAPE_MODE, cfg_word_t'({$urandom(), shape}));
        write_register(REG_POINT_A, cfg_word_t'(pts[0]));
        write_register(REG_POINT_B, cfg_word_t'(pts[1]));
        write_register(REG_POINT_C, cfg_word_t'(pts[2]));
        write_register(REG_POINT_D, cfg_word_t'(pts[3]));
        if (stray)
            write_register(CFG_INDEX_BITS'(REG_POINT_D + 1 + $urandom_range(0, 2)),
                           cfg_word_t'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    task automatic push_crisp(input int v);
        crisp_queue.push_back(crisp_t'(v));
        issued_count++;
    endtask

    // Hold until every queued sample was taken and its degree came back
    task automatic wait_for_results();
        do
            @(posedge clk);
        while (accepted_count != issued_count || expected_degrees.size() != 0);
    endtask

    // Driver: advance to the next sample once the held one transfers, or
    // idle at random by dropping start and putting noise on the data bus.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || !busy)
        begin
            if (crisp_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                start       <= 1'b1;
                crisp_value <= crisp_queue.pop_front();
            end
            else
            begin
                start       <= 1'b0;
                crisp_value <= crisp_t'($urandom());
            end
        end
    end

    // Monitor: track register writes, predict on each input transfer and
    // check every done strobe against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SHAPE_MODE: set_shape = fme_shape_t'(cfg_data[1:0]);
                    REG_POINT_A:    set_a     = cfg_data;
                    REG_POINT_B:    set_b     = cfg_data;
                    REG_POINT_C:    set_c     = cfg_data;
                    REG_POINT_D:    set_d     = cfg_data;
                    default:        ;
                endcase
            end
            if (done)
            begin
                if (expected_degrees.size() == 0)
                    report_mismatch($sformatf("degree %0d with no item outstanding", degree));
                else if (degree !== expected_degrees[0])
                    report_mismatch($sformatf("result %0d: degree %0d, predicted %0d",
                                              result_count, degree, expected_degrees[0]));
                if (expected_degrees.size() != 0)
                    void'(expected_degrees.pop_front());
                result_count++;
            end
            if (start && !busy)
            begin
                expected_degrees.push_back(membership_degree(crisp_value));
                accepted_count++;
            end
        end
    end

    initial
    begin
        int         phase;
        int         random_issued;
        int         n;
        fme_shape_t shape;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset state: triangle collapsed to a point, so x = 0 hits the 0/0 ramp
        push_crisp(0);
        push_crisp(-32768);
        push_crisp(32767);
        wait_for_results();

        // Trapezoid spanning the full range
        pts = '{-32768, -1000, 1000, 32767};
        load_shape(SHAPE_TRAPEZOID, 1'b0);
        push_crisp(-32768);
        push_crisp(-20000);
        push_crisp(0);
        push_crisp(1000);
        push_crisp(20000);
        push_crisp(32767);
        wait_for_results();

        // Falling shoulder, edges on both sides of each breakpoint
        pts = '{-10, 10, 0, 0};
        load_shape(SHAPE_L, 1'b0);
        push_crisp(-11);
        push_crisp(-10);
        push_crisp(0);
        push_crisp(9);
        push_crisp(10);
        wait_for_results();

        // Rising shoulder
        pts = '{-5, 5, 0, 0};
        load_shape(SHAPE_GAMMA, 1'b0);
        push_crisp(-6);
        push_crisp(-5);
        push_crisp(0);
        push_crisp(4);
        push_crisp(5);
        wait_for_results();

        // Triangle with breakpoints out of order, plus a write to an unused index
        pts = '{50, 0, -50, 0};
        load_shape(SHAPE_TRIANGLE, 1'b1);
        push_crisp(0);
        push_crisp(50);
        push_crisp(-50);
        wait_for_results();

        // Random shapes; one long phase runs with no idle cycles at all
        phase         = 0;
        random_issued = 0;
        while (random_issued < RANDOM_ITEMS)
        begin
            make_points();
            shape    = fme_shape_t'($urandom_range(0, 3));
            n        = (phase == NO_IDLE_PHASE) ? 250 : $urandom_range(20, 60);
            idle_pct = (phase == NO_IDLE_PHASE) ? 0 : 37;
            load_shape(shape, $urandom_range(0, 3) == 0);
            repeat (n)
                push_crisp(pick_crisp());
            random_issued += n;
            wait_for_results();
            phase++;
        end

        // Let any stray strobe show up before the verdict
        repeat (LATENCY + 2)
            @(posedge clk);
        if (expected_degrees.size() != 0)
            report_mismatch($sformatf("%0d predicted degrees never arrived",
                                      expected_degrees.size()));

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(TIMEOUT_NS);
        $display("TIMEOUT after %0d results", result_count);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
